// ===== rtl/srl_pkg.sv =====
// srl_pkg: shared constants, operation and status codes, command struct
// for the sorted record list. no dependencies.

package srl_pkg;

    // default table depth
    localparam int DefCapacity = 16;

    // field widths
    localparam int ModeW   = 2;
    localparam int ScoreW  = 16;
    localparam int TagW    = 16;
    localparam int PosW    = 4;
    localparam int StatusW = 3;
    localparam int CountW  = 5;

    // stream widths, rounded up to whole bytes
    localparam int STdataW = 40;
    localparam int MTdataW = 40;

    // operation codes carried in s_tuser
    localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
    localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;
    localparam logic [ModeW-1:0] MODE_READ   = 2'd2;

    // result status codes carried in m_tuser
    localparam logic [StatusW-1:0] ST_INSERTED    = 3'd0;
    localparam logic [StatusW-1:0] ST_REMOVED     = 3'd1;
    localparam logic [StatusW-1:0] ST_NOT_FOUND   = 3'd2;
    localparam logic [StatusW-1:0] ST_EMPTY       = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL_OR_BAD = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted transaction
        logic exec;      // apply the operation and load the result register
    } srl_cmd_t;

endpackage

// ===== rtl/srl_ctrl.sv =====
// srl_ctrl: controller state machine for the sorted record list.
// depends on srl_pkg for the command struct.

module srl_ctrl
    import srl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output srl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    // result register can take a new transaction when empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.load_in    = 1'b0;
        cmd.exec       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/srl_dp.sv =====
// srl_dp: datapath of the sorted record list: a row of compare-and-shift
// cells, the record count, the read mux and the result register.
// depends on srl_pkg for widths and codes.

module srl_dp
    import srl_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  srl_cmd_t           cmd,
    input  logic [STdataW-1:0] in_tdata,   // score, record_tag, position
    input  logic [ModeW-1:0]   in_tuser,   // mode
    output logic [MTdataW-1:0] out_tdata,  // entry_count, out_score, out_tag
    output logic [StatusW-1:0] out_tuser   // status
);

    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ExtW = CntW + CountW;

    // captured transaction
    logic [ModeW-1:0]         mode_reg;
    logic signed [ScoreW-1:0] score_reg;
    logic [TagW-1:0]          tag_reg;
    logic [PosW-1:0]          pos_reg;

    // record cells and count
    logic signed [ScoreW-1:0] score_cell_reg [CAPACITY];
    logic [TagW-1:0]          tag_cell_reg   [CAPACITY];
    logic [CntW-1:0]          count_reg, count_next;

    // result register
    logic [StatusW-1:0]       status_reg, status_next;
    logic [CountW-1:0]        ecount_reg;
    logic signed [ScoreW-1:0] rscore_reg, rscore_next;
    logic [TagW-1:0]          rtag_reg, rtag_next;

    logic [CAPACITY-1:0] valid_vec, gt_vec, eq_vec;
    logic [CAPACITY:0]   gt_left;
    logic                full, empty, found, do_ins, do_rem, rd_ok;
    logic [ExtW-1:0]     pos_ext, cnt_ext, cnt_next_ext;
    logic [IdxW-1:0]     rd_idx;

    // capture the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg  <= in_tuser;
            score_reg <= in_tdata[ScoreW-1:0];
            tag_reg   <= in_tdata[ScoreW +: TagW];
            pos_reg   <= in_tdata[ScoreW+TagW +: PosW];
        end
    end

    // per-cell compares against the captured score
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            valid_vec[k] = CntW'(k) < count_reg;
            gt_vec[k]    = valid_vec[k] && (score_cell_reg[k] > score_reg);
            eq_vec[k]    = valid_vec[k] && (score_cell_reg[k] == score_reg);
        end
    end

    // cell k takes the new record when its left neighbor stays ahead
    assign gt_left = {gt_vec, 1'b1};

    assign full    = (count_reg == CntW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign found   = |eq_vec;
    assign pos_ext = ExtW'(pos_reg);
    assign cnt_ext = ExtW'(count_reg);
    assign rd_idx  = pos_ext[IdxW-1:0];
    assign do_ins  = (mode_reg == MODE_INSERT) && !full;
    assign do_rem  = (mode_reg == MODE_REMOVE) && !empty && found;
    assign rd_ok   = (mode_reg == MODE_READ) && !empty && (pos_ext < cnt_ext);

    // status, count and read data of the result
    always_comb begin
        count_next  = count_reg;
        rscore_next = '0;
        rtag_next   = '0;
        case (mode_reg)
            MODE_INSERT: begin
                status_next = full ? ST_FULL_OR_BAD : ST_INSERTED;
                if (do_ins) begin
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!found) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    status_next = ST_REMOVED;
                    count_next  = count_reg - 1'b1;
                end
            end
            MODE_READ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (!rd_ok) begin
                    status_next = ST_FULL_OR_BAD;
                end else begin
                    status_next = ST_INSERTED;
                    rscore_next = score_cell_reg[rd_idx];
                    rtag_next   = tag_cell_reg[rd_idx];
                end
            end
            default: begin
                status_next = ST_FULL_OR_BAD;
            end
        endcase
    end

    assign cnt_next_ext = ExtW'(count_next);

    // compare-and-shift cells
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [ScoreW-1:0] left_score, right_score;
        logic [TagW-1:0]          left_tag, right_tag;

        if (k == 0) begin : g_head
            assign left_score = score_reg;
            assign left_tag   = tag_reg;
        end else begin : g_body
            assign left_score = gt_left[k] ? score_reg : score_cell_reg[k-1];
            assign left_tag   = gt_left[k] ? tag_reg : tag_cell_reg[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_score = score_cell_reg[k];
            assign right_tag   = tag_cell_reg[k];
        end else begin : g_next
            assign right_score = score_cell_reg[k+1];
            assign right_tag   = tag_cell_reg[k+1];
        end

        // insert shifts right from the slot, remove shifts left from the match
        always_ff @(posedge aclk) begin
            if (cmd.exec && !gt_vec[k]) begin
                if (do_ins) begin
                    score_cell_reg[k] <= left_score;
                    tag_cell_reg[k]   <= left_tag;
                end else if (do_rem) begin
                    score_cell_reg[k] <= right_score;
                    tag_cell_reg[k]   <= right_tag;
                end
            end
        end
    end

    // record count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            ecount_reg <= cnt_next_ext[CountW-1:0];
            rscore_reg <= rscore_next;
            rtag_reg   <= rtag_next;
        end
    end

    assign out_tuser = status_reg;
    assign out_tdata = {(MTdataW - CountW - ScoreW - TagW)'(0), rtag_reg, rscore_reg,
                        ecount_reg};

endmodule

// ===== rtl/sorted_record_list.sv =====
// sorted_record_list: top level, joins the controller and the datapath.
// depends on srl_pkg, srl_ctrl and srl_dp.
//
// keeps up to CAPACITY records (signed score, tag) in descending score order
// input transaction: s_tuser = mode (0 insert, 1 remove by score, 2 read);
//   s_tdata = score, record_tag, position from bit 0 up
// result transaction, one per input: m_tuser = status; m_tdata = record
//   count after the operation, read score, read tag from bit 0 up
// an insert lands ahead of equal scores; a full table refuses it
// a remove deletes the first record with a score equal to the key
// the input is captured when accepted; then the execute state applies the
//   operation across all cells and loads the result register
// a single item is held in the controller: another input is accepted only
//   after execute; it is taken while the previous result still waits on
//   m_tready, and execute waits until the result register is free
// reset (aresetn low, synchronous) empties the table and drops any result

module sorted_record_list
    import srl_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STdataW-1:0] s_tdata,   // score[15:0], record_tag[31:16], position[35:32]
    input  logic [ModeW-1:0]   s_tuser,   // mode[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MTdataW-1:0] m_tdata,   // entry_count[4:0], out_score[20:5], out_tag[36:21]
    output logic [StatusW-1:0] m_tuser    // status[2:0]
);

    srl_cmd_t cmd;

    // controller
    srl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath
    srl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

endmodule

// ===== rtl/srl_checker.sv =====
// srl_checker: port-level assertions for sorted_record_list, bound to the
// top level. depends on srl_pkg for widths and status codes.

module srl_checker
    import srl_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MTdataW-1:0] m_tdata,
    input logic [StatusW-1:0] m_tuser
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted during execute");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_INSERTED) || (m_tuser == ST_REMOVED) ||
                     (m_tuser == ST_NOT_FOUND) || (m_tuser == ST_EMPTY) ||
                     (m_tuser == ST_FULL_OR_BAD))
        else $error("undefined status code");

    // an empty report always comes with a zero count and no record
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata == '0))
        else $error("empty status with nonzero count or record");

endmodule

bind sorted_record_list srl_checker u_srl_checker (.*);
